// ===== rtl/npps_pkg.sv =====
// Package for the nonpreemptive priority scheduler.
// Holds field widths, operation codes, the entry word and the sequencer states.
// It depends on nothing else.
`default_nettype none

package npps_pkg;

    localparam int PRIO_W = 4;
    localparam int TIME_W = 10;
    localparam int IDX_W  = 4;
    localparam int TICK_W = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] need;
        logic [TIME_W-1:0] used;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PICK = 5'b00100,
        S_RD   = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/npps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the process table entries; it depends on no package.
`default_nettype none

module npps_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/nonpreemptive_priority_scheduler_unit.sv =====
// Load: written to the table when accepted. Tick with a process already running: accept,
// table read, update. Tick with no process running: accept, a scan of all MAX_PROCS entries
// that reads one table entry per cycle from the RAM, pick, table read, update.
// One item is in work at a time; a full output register holds the tick in its update cycle.
// Synchronous active-low reset clears the flags, the sequencer and sets the tick to one.
// Uses npps_pkg and npps_ram.
`default_nettype none

module nonpreemptive_priority_scheduler_unit #(
    parameter int MAX_PROCS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_index[3:0], priority_in[7:4], arrival_in[17:8], need_in[27:18], zero [31:28]
    input  wire [31:0]  i_s_axis_tdata,
    // operation[0]
    input  wire         i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // running_id[3:0], used_units[13:4], just_finished[14], all_done[15], time_now[31:16]
    output logic [31:0] o_m_axis_tdata,
    // running_valid[0]
    output logic        o_m_axis_tuser
);

    localparam int SLOT_W = $clog2(MAX_PROCS);
    localparam int ENT_W  = $bits(npps_pkg::t_entry);

    npps_pkg::t_state r_state, n_state;

    logic [SLOT_W-1:0]              r_cnt;
    logic                           r_cmp_act;
    logic [SLOT_W-1:0]              r_cmp_idx;
    logic                           r_found;
    logic [npps_pkg::PRIO_W-1:0]    r_best_prio;
    logic [npps_pkg::TIME_W-1:0]    r_best_arr;
    logic [npps_pkg::TIME_W-1:0]    r_best_rem;
    logic [SLOT_W-1:0]              r_best_idx;
    logic                           r_run;
    logic [SLOT_W-1:0]              r_run_slot;
    logic [npps_pkg::TICK_W-1:0]    r_tick;
    logic [MAX_PROCS-1:0]           r_loaded;
    logic [MAX_PROCS-1:0]           r_finished;
    logic                           r_out_valid;
    logic                           r_out_user;
    logic [31:0]                    r_out_data;

    logic                           s_acc;
    logic                           in_op;
    logic [npps_pkg::IDX_W-1:0]     in_idx;
    logic                           load_ok;
    logic [SLOT_W-1:0]              load_slot;
    npps_pkg::t_entry               load_ent;
    npps_pkg::t_entry               ram_q;
    npps_pkg::t_entry               upd_ent;
    logic                           ram_we;
    logic [SLOT_W-1:0]              ram_waddr;
    logic [ENT_W-1:0]               ram_wdata;
    logic [SLOT_W-1:0]              ram_raddr;
    logic [npps_pkg::TIME_W-1:0]    cand_rem;
    logic                           cand_elig;
    logic                           cand_better;
    logic                           take;
    logic                           upd_fire;
    logic [npps_pkg::TIME_W-1:0]    used_inc;
    logic                           fin;
    logic [MAX_PROCS-1:0]           fin_mask;
    logic                           done;

    assign o_s_axis_tready = (r_state == npps_pkg::S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op           = i_s_axis_tuser;
    assign in_idx          = i_s_axis_tdata[3:0];
    assign load_ok         = (in_op == npps_pkg::OP_LOAD) && (32'(in_idx) < MAX_PROCS);
    assign load_slot       = SLOT_W'(in_idx);

    always_comb begin
        load_ent.prio    = i_s_axis_tdata[7:4];
        load_ent.arrival = i_s_axis_tdata[17:8];
        load_ent.need    = (i_s_axis_tdata[27:18] == '0) ? 10'd1 : i_s_axis_tdata[27:18];
        load_ent.used    = '0;
    end

    // Scan compare against the best candidate so far.
    assign cand_rem  = ram_q.need - ram_q.used;
    assign cand_elig = r_loaded[r_cmp_idx] && !r_finished[r_cmp_idx]
                     && ({6'd0, ram_q.arrival} <= r_tick);
    always_comb begin
        priority if (!r_found) begin
            cand_better = 1'b1;
        end else if (ram_q.prio != r_best_prio) begin
            cand_better = ram_q.prio > r_best_prio;
        end else if (ram_q.arrival != r_best_arr) begin
            cand_better = ram_q.arrival < r_best_arr;
        end else begin
            cand_better = cand_rem < r_best_rem;
        end
    end
    assign take = r_cmp_act && cand_elig && cand_better;

    // Update of the running process.
    assign upd_fire = (r_state == npps_pkg::S_UPD) && (!r_out_valid || i_m_axis_tready);
    assign used_inc = (ram_q.used == '1) ? ram_q.used : ram_q.used + 10'd1;
    assign fin      = used_inc >= ram_q.need;
    always_comb begin
        upd_ent      = ram_q;
        upd_ent.used = used_inc;
        fin_mask     = '0;
        if (r_run && fin) begin
            fin_mask[r_run_slot] = 1'b1;
        end
    end
    assign done = ~|(r_loaded & ~(r_finished | fin_mask));

    always_comb begin
        ram_we    = (s_acc && load_ok) || (upd_fire && r_run);
        ram_waddr = (r_state == npps_pkg::S_IDLE) ? load_slot : r_run_slot;
        ram_wdata = (r_state == npps_pkg::S_IDLE) ? load_ent : upd_ent;
        ram_raddr = (r_state == npps_pkg::S_SCAN) ? r_cnt : r_run_slot;
    end

    npps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_PROCS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npps_pkg::S_IDLE: begin
                if (s_acc && in_op == npps_pkg::OP_TICK) begin
                    n_state = r_run ? npps_pkg::S_RD : npps_pkg::S_SCAN;
                end
            end
            npps_pkg::S_SCAN: begin
                if (r_cnt == SLOT_W'(MAX_PROCS - 1)) begin
                    n_state = npps_pkg::S_PICK;
                end
            end
            npps_pkg::S_PICK: n_state = npps_pkg::S_RD;
            npps_pkg::S_RD:   n_state = npps_pkg::S_UPD;
            npps_pkg::S_UPD: begin
                if (upd_fire) begin
                    n_state = npps_pkg::S_IDLE;
                end
            end
            default: n_state = npps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npps_pkg::S_IDLE;
            r_cnt       <= '0;
            r_cmp_act   <= 1'b0;
            r_found     <= 1'b0;
            r_run       <= 1'b0;
            r_run_slot  <= '0;
            r_tick      <= 16'd1;
            r_loaded    <= '0;
            r_finished  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (o_m_axis_tvalid && i_m_axis_tready && !upd_fire) begin
                r_out_valid <= 1'b0;
            end

            if (take) begin
                r_found     <= 1'b1;
                r_best_prio <= ram_q.prio;
                r_best_arr  <= ram_q.arrival;
                r_best_rem  <= cand_rem;
                r_best_idx  <= r_cmp_idx;
            end

            unique case (r_state)
                npps_pkg::S_IDLE: begin
                    r_cnt     <= '0;
                    r_cmp_act <= 1'b0;
                    r_found   <= 1'b0;
                    if (s_acc && load_ok) begin
                        r_loaded[load_slot]   <= 1'b1;
                        r_finished[load_slot] <= 1'b0;
                        if (r_run && r_run_slot == load_slot) begin
                            r_run <= 1'b0;
                        end
                    end
                end
                npps_pkg::S_SCAN: begin
                    r_cmp_act <= 1'b1;
                    r_cmp_idx <= r_cnt;
                    if (r_cnt != SLOT_W'(MAX_PROCS - 1)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                npps_pkg::S_PICK: begin
                    r_cmp_act  <= 1'b0;
                    r_run      <= r_found || take;
                    r_run_slot <= take ? r_cmp_idx : r_best_idx;
                end
                npps_pkg::S_RD: begin
                end
                npps_pkg::S_UPD: begin
                    if (upd_fire) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_run;
                        r_out_data  <= {r_tick, done, r_run && fin,
                                        r_run ? used_inc : 10'd0,
                                        r_run ? 4'(r_run_slot) : 4'd0};
                        r_finished  <= r_finished | fin_mask;
                        if (r_run && fin) begin
                            r_run <= 1'b0;
                        end
                        if (r_tick != npps_pkg::TICK_MAX) begin
                            r_tick <= r_tick + 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_run_slot_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_loaded[r_run_slot] && !r_finished[r_run_slot]))
        else $error("running slot is not a live entry");

    a_upd_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> (r_out_valid && r_state == npps_pkg::S_IDLE))
        else $error("update did not leave a result");

    a_scan_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmp_act || r_state == npps_pkg::S_UPD) |-> !o_s_axis_tready)
        else $error("input taken while a tick is in work");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_nonpreemptive_priority_scheduler_unit.sv =====
// Self-checking testbench for nonpreemptive_priority_scheduler_unit.
// Drives load and tick transfers with random gaps and back-pressure and checks every tick
// report against a behavioral scheduler or a typed report. Depends on npps_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_nonpreemptive_priority_scheduler_unit;

    typedef struct packed {
        bit        valid;
        bit [3:0]  id;
        bit [9:0]  used;
        bit        fin;
        bit        done;
        bit [15:0] tnow;
    } t_tick_report;

    typedef struct {
        logic         op;
        bit [3:0]     idx;
        bit [3:0]     prio;
        bit [9:0]     arr;
        bit [9:0]     need;
        bit           typed;
        t_tick_report want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic [31:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        i_m_axis_tready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    bit          loaded_tab[16];
    bit          fin_tab[16];
    bit [3:0]    prio_tab[16];
    bit [9:0]    arr_tab[16];
    bit [9:0]    need_tab[16];
    bit [9:0]    used_tab[16];
    bit          busy;
    bit [3:0]    busy_slot;
    bit [15:0]   tick_cnt;

    t_tick_report tick_reports_q[$];
    t_stim_row    directed_rows[$];
    t_tick_report got_report;
    t_tick_report want_report;
    int           err_count;
    int           results_seen;
    bit           quiet;
    bit           held;
    int           stall_left;

    nonpreemptive_priority_scheduler_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit table_drained();
        bit drained;
        drained = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (loaded_tab[i] && !fin_tab[i]) begin
                drained = 1'b0;
            end
        end
        return drained;
    endfunction

    function automatic bit schedule_item(input logic op, input bit [3:0] idx,
                                         input bit [3:0] prio, input bit [9:0] arr,
                                         input bit [9:0] need, output t_tick_report rep);
        int best;
        bit found;
        bit take;
        rep = '0;
        if (op == npps_pkg::OP_LOAD) begin
            prio_tab[idx]   = prio;
            arr_tab[idx]    = arr;
            need_tab[idx]   = (need == 10'd0) ? 10'd1 : need;
            used_tab[idx]   = 10'd0;
            loaded_tab[idx] = 1'b1;
            fin_tab[idx]    = 1'b0;
            if (busy && busy_slot == idx) begin
                busy = 1'b0;
            end
            return 1'b0;
        end
        if (!busy) begin
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < 16; i++) begin
                if (loaded_tab[i] && !fin_tab[i] && arr_tab[i] <= tick_cnt) begin
                    if (!found) begin
                        take = 1'b1;
                    end else if (prio_tab[i] != prio_tab[best]) begin
                        take = prio_tab[i] > prio_tab[best];
                    end else if (arr_tab[i] != arr_tab[best]) begin
                        take = arr_tab[i] < arr_tab[best];
                    end else begin
                        take = (need_tab[i] - used_tab[i]) < (need_tab[best] - used_tab[best]);
                    end
                    if (take) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found) begin
                busy      = 1'b1;
                busy_slot = 4'(best);
            end
        end
        if (busy) begin
            if (used_tab[busy_slot] != 10'h3FF) begin
                used_tab[busy_slot]++;
            end
            rep.valid = 1'b1;
            rep.id    = busy_slot;
            rep.used  = used_tab[busy_slot];
            if (used_tab[busy_slot] >= need_tab[busy_slot]) begin
                fin_tab[busy_slot] = 1'b1;
                busy               = 1'b0;
                rep.fin            = 1'b1;
            end
        end
        rep.done = table_drained();
        rep.tnow = tick_cnt;
        if (tick_cnt != npps_pkg::TICK_MAX) begin
            tick_cnt++;
        end
        return 1'b1;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic op, input bit [3:0] idx, input bit [3:0] prio,
                             input bit [9:0] arr, input bit [9:0] need,
                             input bit typed = 1'b0, input t_tick_report want = '0);
        t_tick_report rep;
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, need, arr, prio, idx};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        if (schedule_item(op, idx, prio, arr, need, rep)) begin
            tick_reports_q = {tick_reports_q, (typed ? want : rep)};
        end
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string field, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            got_report = {o_m_axis_tuser, o_m_axis_tdata[3:0], o_m_axis_tdata[13:4],
                          o_m_axis_tdata[14], o_m_axis_tdata[15], o_m_axis_tdata[31:16]};
            if (tick_reports_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected transfer, expected none, got %h", $time, got_report);
            end else begin
                want_report = tick_reports_q.pop_front();
                check_field("running_valid", want_report.valid, got_report.valid);
                check_field("running_id", want_report.id, got_report.id);
                check_field("used_units", want_report.used, got_report.used);
                check_field("just_finished", want_report.fin, got_report.fin);
                check_field("all_done", want_report.done, got_report.done);
                check_field("time_now", want_report.tnow, got_report.tnow);
            end
        end
    end

    // The receiver stalls once for a long stretch so that the block backs up its input.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 150) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                stall_left = idle_len();
                i_m_axis_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin
        #15_000_000;
        $display("tb_nonpreemptive_priority_scheduler_unit NOT OK");
        $finish;
    end

    initial begin
        int sent;
        int n_loads;
        int n_ticks;
        bit [9:0] arr;
        bit [9:0] need;
        int r;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = npps_pkg::OP_LOAD;
        tick_cnt        = 16'd1;

        directed_rows = '{
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b1,
              t_tick_report'{0, 0, 0, 0, 1, 1}},
            '{npps_pkg::OP_LOAD, 4'd0, 4'd15, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_LOAD, 4'd15, 4'd0, 10'd1023, 10'd1023, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b1,
              t_tick_report'{1, 0, 1, 1, 0, 2}},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b1,
              t_tick_report'{0, 0, 0, 0, 0, 3}},
            '{npps_pkg::OP_LOAD, 4'd3, 4'd7, 10'd2, 10'd3, 1'b0, '0},
            '{npps_pkg::OP_LOAD, 4'd4, 4'd7, 10'd2, 10'd2, 1'b0, '0},
            '{npps_pkg::OP_LOAD, 4'd5, 4'd7, 10'd1, 10'd4, 1'b0, '0},
            '{npps_pkg::OP_LOAD, 4'd6, 4'd7, 10'd1, 10'd4, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_LOAD, 4'd5, 4'd2, 10'd4, 10'd2, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd9, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_LOAD, 4'd10, 4'd10, 10'd5, 10'd1000, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0},
            '{npps_pkg::OP_TICK, 4'd0, 4'd0, 10'd0, 10'd0, 1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].prio,
                      directed_rows[k].arr, directed_rows[k].need,
                      directed_rows[k].typed, directed_rows[k].want);
        end

        // Batches of loads followed by a run of ticks, with reloads mixed in.
        sent = 0;
        while (sent < 700) begin
            quiet   = ($urandom_range(0, 99) < 15);
            n_loads = $urandom_range(1, 6);
            n_ticks = $urandom_range(1, 25);
            for (int j = 0; j < n_loads + n_ticks; j++) begin
                if (j < n_loads || $urandom_range(0, 9) == 0) begin
                    if (tick_cnt <= 16'd1023 && $urandom_range(0, 9) < 7) begin
                        arr = (tick_cnt + $urandom_range(0, 6) > 1023) ? 10'd1023
                            : 10'(tick_cnt + $urandom_range(0, 6));
                    end else begin
                        arr = 10'($urandom_range(0, 1023));
                    end
                    r = $urandom_range(0, 99);
                    need = (r < 85) ? 10'($urandom_range(0, 6))
                         : (r < 95) ? 10'($urandom_range(7, 40))
                         : 10'($urandom_range(0, 1023));
                    send_item(npps_pkg::OP_LOAD, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), arr, need);
                end else begin
                    send_item(npps_pkg::OP_TICK, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)),
                              10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
                end
                sent++;
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (tick_reports_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_nonpreemptive_priority_scheduler_unit OK");
        end else begin
            $display("tb_nonpreemptive_priority_scheduler_unit NOT OK");
        end
        $finish;
    end

endmodule

// ===== nonpreemptive_priority_scheduler_unit.f =====
rtl/npps_pkg.sv
rtl/npps_ram.sv
rtl/nonpreemptive_priority_scheduler_unit.sv
tb/tb_nonpreemptive_priority_scheduler_unit.sv
